// ----- rtl/hsmdp_pkg.sv -----
// Shared types and constants for the handle slot map with dense packing.
// Used by the interfaces, controller, datapath, top level and checker.
package hsmdp_pkg;

  localparam int unsigned SLOTS   = 64;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W   = SLOT_W + 1;
  localparam int unsigned GRP_SZ  = 8;
  localparam int unsigned GROUPS  = SLOTS / GRP_SZ;
  localparam int unsigned GRP_W   = $clog2(GRP_SZ);
  localparam int unsigned GIDX_W  = $clog2(GROUPS);
  localparam int unsigned HANDLE_W = 7;
  localparam int unsigned STAT_W  = 2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

  localparam logic MODE_CREATE = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef struct packed {
    logic load;
    logic grp;
    logic sel;
    logic del_rd;
    logic commit;
  } hsmdp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } hsmdp_stat_t;

endpackage

// ----- rtl/hsmdp_if.sv -----
// Valid/ready channel interfaces for request and result transactions.
// Depends on hsmdp_pkg for field widths.
interface hsmdp_in_if import hsmdp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, output mode, output handle, input ready);
  modport sink   (input valid, input mode, input handle, output ready);
endinterface

interface hsmdp_out_if import hsmdp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [HANDLE_W-1:0] new_handle;
  logic [SLOT_W-1:0]   dense_index;
  logic                move_valid;
  logic [SLOT_W-1:0]   moved_from;
  logic [SLOT_W-1:0]   moved_to;
  logic [CNT_W-1:0]    live_count;

  modport source (output valid, output status, output new_handle, output dense_index,
                  output move_valid, output moved_from, output moved_to,
                  output live_count, input ready);
  modport sink   (input valid, input status, input new_handle, input dense_index,
                  input move_valid, input moved_from, input moved_to,
                  input live_count, output ready);
endinterface

// ----- rtl/hsmdp_ctrl.sv -----
// Sequencer for create/delete transactions of the slot map.
// Depends on hsmdp_pkg; drives commands into hsmdp_dp.
module hsmdp_ctrl import hsmdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_mode_i,
  output logic        in_ready_o,
  input  hsmdp_stat_t stat_i,
  output hsmdp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GRP    = 3'd1;
  localparam logic [2:0] S_SEL    = 3'd2;
  localparam logic [2:0] S_DEL_RD = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = (in_mode_i == MODE_DELETE) ? S_DEL_RD : S_GRP;
        end
      end
      S_GRP: begin
        cmd_o.grp = 1'b1;
        state_d   = S_SEL;
      end
      S_SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = S_COMMIT;
      end
      S_DEL_RD: begin
        cmd_o.del_rd = 1'b1;
        state_d      = S_COMMIT;
      end
      S_COMMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/hsmdp_dp.sv -----
// Datapath: slot valid bits, live count, free-slot search tree, slot and dense tables.
// Depends on hsmdp_pkg; commanded by hsmdp_ctrl.
module hsmdp_dp import hsmdp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SLOT_W-1:0]   cfg_wdata_i,
  input  logic                in_mode_i,
  input  logic [HANDLE_W-1:0] in_handle_i,
  input  hsmdp_cmd_t          cmd_i,
  output hsmdp_stat_t         stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STAT_W-1:0]   out_status_o,
  output logic [HANDLE_W-1:0] out_new_handle_o,
  output logic [SLOT_W-1:0]   out_dense_index_o,
  output logic                out_move_valid_o,
  output logic [SLOT_W-1:0]   out_moved_from_o,
  output logic [SLOT_W-1:0]   out_moved_to_o,
  output logic [CNT_W-1:0]    out_live_count_o
);

  logic [SLOT_W-1:0]   start_q;
  logic [SLOTS-1:0]    valid_q;
  logic [CNT_W-1:0]    count_q;
  logic                mode_q;
  logic [HANDLE_W-1:0] handle_q;

  // search tree registers
  logic [GROUPS-1:0]   any_hi_q, any_all_q;
  logic [GRP_W-1:0]    first_hi_q  [GROUPS];
  logic [GRP_W-1:0]    first_all_q [GROUPS];
  logic [GROUPS-1:0]   any_hi_d, any_all_d;
  logic [GRP_W-1:0]    first_hi_d  [GROUPS];
  logic [GRP_W-1:0]    first_all_d [GROUPS];
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                found_q, found_d;

  // tables
  logic [SLOT_W-1:0]   tgt_mem   [SLOTS];
  logic [SLOT_W-1:0]   owner_mem [SLOTS];
  logic [SLOT_W-1:0]   tgt_rd_q, owner_rd_q;
  logic                tgt_we, owner_we;
  logic [SLOT_W-1:0]   tgt_waddr, tgt_wdata, owner_waddr, owner_wdata;
  logic [SLOT_W-1:0]   hidx, last_idx;
  logic                bad_q, bad_d;

  logic                out_valid_q;
  logic [STAT_W-1:0]   status_q, status_d;
  logic [HANDLE_W-1:0] new_handle_q, new_handle_d;
  logic [SLOT_W-1:0]   dense_q, dense_d, from_q, from_d, to_q, to_d;
  logic                mv_q, mv_d;
  logic [CNT_W-1:0]    live_q, live_d;

  logic                create_ok, delete_ok, move;
  logic [SLOTS-1:0]    free_all, free_hi;

  assign hidx     = SLOT_W'(handle_q - HANDLE_W'(1));
  assign last_idx = SLOT_W'(count_q - CNT_W'(1));

  // group stage: per-group any and first free, for slots at/after start and for all
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_all[i] = !valid_q[i];
      free_hi[i]  = !valid_q[i] && (SLOT_W'(i) >= start_q);
    end
    for (int g = 0; g < GROUPS; g++) begin
      any_hi_d[g]    = |free_hi[g*GRP_SZ +: GRP_SZ];
      any_all_d[g]   = |free_all[g*GRP_SZ +: GRP_SZ];
      first_hi_d[g]  = '0;
      first_all_d[g] = '0;
      for (int j = GRP_SZ - 1; j >= 0; j--) begin
        if (free_hi[g*GRP_SZ + j]) first_hi_d[g] = GRP_W'(j);
        if (free_all[g*GRP_SZ + j]) first_all_d[g] = GRP_W'(j);
      end
    end
  end

  // select stage: first group with a free slot at/after start, else first overall
  always_comb begin
    slot_d  = '0;
    found_d = |any_all_q;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (any_all_q[g]) slot_d = {GIDX_W'(g), first_all_q[g]};
    end
    if (|any_hi_q) begin
      for (int g = GROUPS - 1; g >= 0; g--) begin
        if (any_hi_q[g]) slot_d = {GIDX_W'(g), first_hi_q[g]};
      end
    end
  end

  assign bad_d = (handle_q == '0) || (handle_q > HANDLE_W'(SLOTS)) ||
                 !valid_q[hidx] || (count_q == '0);

  assign create_ok = (mode_q == MODE_CREATE) && found_q && (count_q < CNT_W'(SLOTS));
  assign delete_ok = (mode_q == MODE_DELETE) && !bad_q;
  assign move      = delete_ok && (count_q > CNT_W'(1));

  always_comb begin
    status_d     = STAT_OK;
    new_handle_d = '0;
    dense_d      = '0;
    mv_d         = 1'b0;
    from_d       = '0;
    to_d         = '0;
    live_d       = count_q;
    if (mode_q == MODE_CREATE) begin
      if (create_ok) begin
        new_handle_d = HANDLE_W'(slot_q) + HANDLE_W'(1);
        dense_d      = count_q[SLOT_W-1:0];
        live_d       = count_q + CNT_W'(1);
      end else begin
        status_d = STAT_FULL;
      end
    end else begin
      if (delete_ok) begin
        dense_d = tgt_rd_q;
        live_d  = count_q - CNT_W'(1);
        if (move) begin
          mv_d   = 1'b1;
          from_d = last_idx;
          to_d   = tgt_rd_q;
        end
      end else begin
        status_d = STAT_BAD;
      end
    end
  end

  always_comb begin
    tgt_we      = cmd_i.commit && (create_ok || move);
    owner_we    = tgt_we;
    tgt_waddr   = create_ok ? slot_q : owner_rd_q;
    tgt_wdata   = create_ok ? count_q[SLOT_W-1:0] : tgt_rd_q;
    owner_waddr = create_ok ? count_q[SLOT_W-1:0] : tgt_rd_q;
    owner_wdata = create_ok ? slot_q : owner_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (tgt_we) tgt_mem[tgt_waddr] <= tgt_wdata;
    if (cmd_i.del_rd) tgt_rd_q <= tgt_mem[hidx];
  end

  always_ff @(posedge clk_i) begin
    if (owner_we) owner_mem[owner_waddr] <= owner_wdata;
    if (cmd_i.del_rd) owner_rd_q <= owner_mem[last_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= in_mode_i;
      handle_q <= in_handle_i;
    end
    if (cmd_i.grp) begin
      any_hi_q    <= any_hi_d;
      any_all_q   <= any_all_d;
      first_hi_q  <= first_hi_d;
      first_all_q <= first_all_d;
    end
    if (cmd_i.sel) begin
      slot_q  <= slot_d;
      found_q <= found_d;
    end
    if (cmd_i.del_rd) bad_q <= bad_d;
    if (cmd_i.commit) begin
      status_q     <= status_d;
      new_handle_q <= new_handle_d;
      dense_q      <= dense_d;
      mv_q         <= mv_d;
      from_q       <= from_d;
      to_q         <= to_d;
      live_q       <= live_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) start_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        count_q     <= live_d;
        out_valid_q <= 1'b1;
        if (create_ok) valid_q[slot_q] <= 1'b1;
        if (delete_ok) valid_q[hidx] <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = status_q;
  assign out_new_handle_o  = new_handle_q;
  assign out_dense_index_o = dense_q;
  assign out_move_valid_o  = mv_q;
  assign out_moved_from_o  = from_q;
  assign out_moved_to_o    = to_q;
  assign out_live_count_o  = live_q;

endmodule

// ----- rtl/handle_slot_map_dense_pack_top.sv -----
// Handle slot map with dense packing: 64 slots map stable handles (slot + 1) to
// dense indices 0..count-1. One transaction at a time: a create steps through
// accept, the group stage and select stage of the registered free-slot search
// tree, and commit; a delete steps through accept, a registered read of the slot
// and dense tables, and commit. The result sits in an output register; the next
// request is accepted in the cycle after commit, and commit waits only while the
// previous result is still untaken. Errors (table full, bad handle) come back in
// the status field with the state unchanged.
module handle_slot_map_dense_pack_top import hsmdp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SLOT_W-1:0] cfg_wdata_i,
  hsmdp_in_if.sink          in_i,
  hsmdp_out_if.source       out_o
);

  hsmdp_cmd_t  cmd;
  hsmdp_stat_t stat;

  hsmdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hsmdp_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_mode_i         (in_i.mode),
    .in_handle_i       (in_i.handle),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .out_status_o      (out_o.status),
    .out_new_handle_o  (out_o.new_handle),
    .out_dense_index_o (out_o.dense_index),
    .out_move_valid_o  (out_o.move_valid),
    .out_moved_from_o  (out_o.moved_from),
    .out_moved_to_o    (out_o.moved_to),
    .out_live_count_o  (out_o.live_count)
  );

endmodule

// ----- rtl/hsmdp_chk.sv -----
// Port-level checker for the slot map top level, attached by bind.
// Depends on hsmdp_pkg.
module hsmdp_chk import hsmdp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic [STAT_W-1:0]   status_i,
  input logic [HANDLE_W-1:0] new_handle_i,
  input logic [SLOT_W-1:0]   dense_index_i,
  input logic                move_valid_i,
  input logic [SLOT_W-1:0]   moved_from_i,
  input logic [SLOT_W-1:0]   moved_to_i,
  input logic [CNT_W-1:0]    live_count_i
);

  // full only when every slot is live
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STAT_FULL) |->
      (live_count_i == CNT_W'(SLOTS)) && (new_handle_i == '0))
    else $error("full status with free slots");

  // a move always comes from the last dense entry into the freed hole
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && move_valid_i |->
      (status_i == STAT_OK) && (moved_from_i == live_count_i[SLOT_W-1:0]) &&
      (moved_to_i == dense_index_i))
    else $error("move does not match freed and last dense index");

  // a new handle is bound to the last dense index
  a_create: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (new_handle_i != '0) |->
      (status_i == STAT_OK) && (new_handle_i <= HANDLE_W'(SLOTS)) &&
      (CNT_W'(dense_index_i) == live_count_i - CNT_W'(1)))
    else $error("create result inconsistent");

  // one transaction at a time
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted back to back");

endmodule

bind handle_slot_map_dense_pack_top hsmdp_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .status_i      (out_o.status),
  .new_handle_i  (out_o.new_handle),
  .dense_index_i (out_o.dense_index),
  .move_valid_i  (out_o.move_valid),
  .moved_from_i  (out_o.moved_from),
  .moved_to_i    (out_o.moved_to),
  .live_count_i  (out_o.live_count)
);
